// ----- rtl/smbp_pkg.sv -----
// Shared types and constants of the stream metadata block parser.
package smbp_pkg;

  localparam int unsigned LENGTH_UNIT = 16;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
  localparam int unsigned LEN_W = 12;
  localparam logic [LEN_W-1:0] MAX_BLOCK_LEN_RESET = 12'd4080;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_EQ = 8'h3D;
  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_PAIR  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_LEN    = 2'd1,
    STATUS_NO_NUL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_NAME  = 2'd0,
    MODE_VALUE = 2'd1,
    MODE_STOP  = 2'd2
  } mode_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data;
    status_e          status;
    logic [LEN_W-1:0] len;
  } result_t;

  typedef struct packed {
    logic [2:0]        valid;
    result_t [2:0]     slot;
  } bundle_t;

endpackage

// ----- rtl/smbp_front.sv -----
// Front end: length decode, pair parsing and result bundling per input byte.
module smbp_front import smbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_in_i,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  output bundle_t          bundle_o
);

  logic             in_body_q, in_body_d;
  logic [LEN_W-1:0] remaining_q, remaining_d;
  logic [LEN_W-1:0] total_q, total_d;
  mode_e            mode_q, mode_d;
  logic             held_q, held_d;
  logic [LEN_W-1:0] max_len_q;
  logic [LEN_W-1:0] len_calc;
  logic [LEN_W-1:0] remaining_dec;

  assign len_calc = LEN_W'(byte_in_i[6:0]) * LEN_W'(LENGTH_UNIT);
  assign remaining_dec = remaining_q - LEN_W'(1);

  always_comb begin
    logic cont;
    in_body_d = in_body_q;
    remaining_d = remaining_q;
    total_d = total_q;
    mode_d = mode_q;
    held_d = held_q;
    bundle_o = '0;
    cont = 1'b0;
    if (!in_body_q) begin
      if (byte_in_i[7]) begin
        bundle_o.valid[2] = 1'b1;
        bundle_o.slot[2].kind = KIND_END;
        bundle_o.slot[2].status = STATUS_LEN;
      end else if (len_calc > max_len_q) begin
        bundle_o.valid[2] = 1'b1;
        bundle_o.slot[2].kind = KIND_END;
        bundle_o.slot[2].status = STATUS_LEN;
        bundle_o.slot[2].len = len_calc;
      end else if (len_calc == '0) begin
        total_d = '0;
        bundle_o.valid[2] = 1'b1;
        bundle_o.slot[2].kind = KIND_END;
        bundle_o.slot[2].status = STATUS_OK;
      end else begin
        in_body_d = 1'b1;
        remaining_d = len_calc;
        total_d = len_calc;
        mode_d = MODE_NAME;
        held_d = 1'b0;
      end
    end else begin
      if (mode_q == MODE_NAME || mode_q == MODE_VALUE) begin
        cont = 1'b1;
        if (held_q) begin
          held_d = 1'b0;
          if (mode_q == MODE_NAME && byte_in_i == CHAR_QUOTE) begin
            mode_d = MODE_VALUE;
            cont = 1'b0;
          end else if (mode_q == MODE_VALUE && byte_in_i == CHAR_SEMI) begin
            mode_d = MODE_NAME;
            cont = 1'b0;
            bundle_o.valid[0] = 1'b1;
            bundle_o.slot[0].kind = KIND_PAIR;
          end else begin
            bundle_o.valid[0] = 1'b1;
            bundle_o.slot[0].kind = (mode_q == MODE_NAME) ? KIND_NAME : KIND_VALUE;
            bundle_o.slot[0].data = (mode_q == MODE_NAME) ? CHAR_EQ : CHAR_QUOTE;
          end
        end
        if (cont) begin
          if (byte_in_i == CHAR_NUL) begin
            mode_d = MODE_STOP;
          end else if ((mode_q == MODE_NAME && byte_in_i == CHAR_EQ) ||
                       (mode_q == MODE_VALUE && byte_in_i == CHAR_QUOTE)) begin
            held_d = 1'b1;
          end else begin
            bundle_o.valid[1] = 1'b1;
            bundle_o.slot[1].kind = (mode_q == MODE_NAME) ? KIND_NAME : KIND_VALUE;
            bundle_o.slot[1].data = byte_in_i;
          end
        end
      end
      remaining_d = remaining_dec;
      if (remaining_dec == '0) begin
        bundle_o.valid[2] = 1'b1;
        bundle_o.slot[2].kind = KIND_END;
        bundle_o.slot[2].status = (byte_in_i == CHAR_NUL) ? STATUS_OK : STATUS_NO_NUL;
        bundle_o.slot[2].len = total_q;
        in_body_d = 1'b0;
        remaining_d = '0;
        mode_d = MODE_NAME;
        held_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      remaining_q <= '0;
      total_q <= '0;
      mode_q <= MODE_NAME;
      held_q <= 1'b0;
      max_len_q <= MAX_BLOCK_LEN_RESET;
    end else begin
      if (accept_i) begin
        in_body_q <= in_body_d;
        remaining_q <= remaining_d;
        total_q <= total_d;
        mode_q <= mode_d;
        held_q <= held_d;
      end
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

endmodule

// ----- rtl/smbp_queue.sv -----
// Short bundle queue between the front end and the result stage.
module smbp_queue import smbp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  bundle_t wr_data_i,
  output logic    full_o,
  input  logic    rd_i,
  output bundle_t rd_data_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  bundle_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_i && !rd_i) begin
      count_d = count_q + CntW'(1);
    end else if (!wr_i && rd_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

// ----- rtl/smbp_back.sv -----
// Result stage: unpacks queued bundles into single result words.
module smbp_back import smbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  bundle_t head_i,
  input  logic    head_empty_i,
  output logic    head_rd_o,
  input  logic    pop_i,
  output result_t res_o,
  output logic    last_o
);

  logic [2:0] done_q, done_d;
  logic [2:0] pend;
  logic [2:0] sel;
  logic [1:0] idx;
  logic       fire;

  assign pend = head_i.valid & ~done_q;

  always_comb begin
    if (pend[0]) begin
      idx = 2'd0;
    end else if (pend[1]) begin
      idx = 2'd1;
    end else begin
      idx = 2'd2;
    end
  end

  assign sel = 3'b001 << idx;
  assign res_o = head_i.slot[idx];
  assign last_o = ((pend & ~sel) == '0);
  assign fire = pop_i && !head_empty_i;
  assign head_rd_o = fire && last_o;

  always_comb begin
    done_d = done_q;
    if (fire) begin
      done_d = last_o ? '0 : (done_q | sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else begin
      done_q <= done_d;
    end
  end

endmodule

// ----- rtl/stream_metadata_block_parser.sv -----
// Top level of the stream metadata block parser.
// Input side is a queue write port: a byte word is taken on a rising edge with
// push high and full low. The first byte of a block is the length byte (bits
// 6:0 unsigned in 16-byte units, bit 7 set is an error); body bytes follow.
// Result side is a queue read port: while empty is low the oldest result word
// (kind, data_byte, status, block_len, last) is on the outputs; pop high with
// empty low takes it. last marks the final result word caused by one byte.
// The configuration channel writes max_block_len on cfg_valid_i with
// cfg_ready_o, which is always high; write it only while the block is idle.
// A result's bundle is registered in the bundle queue when its byte is taken.
// Throughput: one byte per cycle while full is low and each byte causes at
// most one result; a byte causing two or three results needs a pop per result
// word, and the bundle queue (QUEUE_DEPTH entries) absorbs that.
// Stalls on the result side fill the bundle queue, then raise full.
// Reset clears the parser to wait for a length byte, empties the queue and
// sets max_block_len to 4080.
module stream_metadata_block_parser import smbp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       byte_in_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_max_block_len_i,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [1:0]       status_o,
  output logic [LEN_W-1:0] block_len_o,
  output logic             last_o
);

  logic    accept;
  bundle_t bundle;
  bundle_t head;
  logic    q_full;
  logic    q_empty;
  logic    q_rd;
  result_t res;

  assign cfg_ready_o = 1'b1;
  assign full = q_full;
  assign accept = push && !q_full;
  assign empty = q_empty;

  smbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .byte_in_i  (byte_in_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_max_block_len_i),
    .bundle_o   (bundle)
  );

  smbp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept && (bundle.valid != '0)),
    .wr_data_i (bundle),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (head),
    .empty_o   (q_empty)
  );

  smbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (q_empty),
    .head_rd_o    (q_rd),
    .pop_i        (pop),
    .res_o        (res),
    .last_o       (last_o)
  );

  assign kind_o = res.kind;
  assign data_byte_o = res.data;
  assign status_o = res.status;
  assign block_len_o = res.len;

endmodule

// ----- verif/stream_metadata_block_parser_tb.sv -----
// Testbench for the stream metadata block parser: queued byte stimulus, predictor, scoreboard.
module stream_metadata_block_parser_tb;
  import smbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_UNITS = 127;

  typedef enum int unsigned {
    TAIL_NUL,
    TAIL_EARLY_NUL,
    TAIL_OPEN,
    TAIL_HELD,
    TAIL_NOISE
  } tail_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data;
    status_e          status;
    logic [LEN_W-1:0] len;
    logic             last;
  } meta_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       byte_in_i = 8'h00;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LEN_W-1:0] cfg_max_block_len_i = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic [1:0]       kind_o;
  logic [7:0]       data_byte_o;
  logic [1:0]       status_o;
  logic [LEN_W-1:0] block_len_o;
  logic             last_o;

  logic [7:0]  pending_bytes[$];
  meta_word_t  expected_words[$];
  meta_word_t  want;
  logic        byte_busy = 1'b0;
  int unsigned push_gap = 0;
  int unsigned pop_gap = 0;
  int unsigned push_calm = 0;
  int unsigned pop_calm = 0;
  int unsigned n_queued = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;

  // predictor state
  logic [LEN_W-1:0] max_len = MAX_BLOCK_LEN_RESET;
  logic             in_body = 1'b0;
  logic [LEN_W-1:0] remaining = '0;
  logic [LEN_W-1:0] total_len = '0;
  mode_e            mode = MODE_NAME;
  logic             held = 1'b0;

  stream_metadata_block_parser dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .byte_in_i           (byte_in_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_max_block_len_i (cfg_max_block_len_i),
    .empty               (empty),
    .pop                 (pop),
    .kind_o              (kind_o),
    .data_byte_o         (data_byte_o),
    .status_o            (status_o),
    .block_len_o         (block_len_o),
    .last_o              (last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  task automatic emit_word(input kind_e k, input logic [7:0] d, input status_e s,
                           input logic [LEN_W-1:0] l);
    meta_word_t w;
    w.kind = k;
    w.data = d;
    w.status = s;
    w.len = l;
    w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic parse_body_byte(input logic [7:0] c);
    if (mode != MODE_NAME && mode != MODE_VALUE) return;
    if (held) begin
      held = 1'b0;
      if (mode == MODE_NAME && c == CHAR_QUOTE) begin
        mode = MODE_VALUE;
        return;
      end
      if (mode == MODE_VALUE && c == CHAR_SEMI) begin
        mode = MODE_NAME;
        emit_word(KIND_PAIR, 8'h00, STATUS_OK, '0);
        return;
      end
      if (mode == MODE_NAME) emit_word(KIND_NAME, CHAR_EQ, STATUS_OK, '0);
      else emit_word(KIND_VALUE, CHAR_QUOTE, STATUS_OK, '0);
    end
    if (c == CHAR_NUL) begin
      mode = MODE_STOP;
      return;
    end
    if ((mode == MODE_NAME && c == CHAR_EQ) || (mode == MODE_VALUE && c == CHAR_QUOTE)) begin
      held = 1'b1;
      return;
    end
    emit_word(mode == MODE_NAME ? KIND_NAME : KIND_VALUE, c, STATUS_OK, '0);
  endtask

  task automatic predict_byte(input logic [7:0] c);
    int unsigned base;
    int unsigned len;
    base = expected_words.size();
    if (!in_body) begin
      len = c[6:0] * LENGTH_UNIT;
      if (c[7]) emit_word(KIND_END, 8'h00, STATUS_LEN, '0);
      else if (len > max_len) emit_word(KIND_END, 8'h00, STATUS_LEN, len[LEN_W-1:0]);
      else if (len == 0) begin
        total_len = '0;
        emit_word(KIND_END, 8'h00, STATUS_OK, '0);
      end else begin
        in_body = 1'b1;
        remaining = len[LEN_W-1:0];
        total_len = len[LEN_W-1:0];
        mode = MODE_NAME;
        held = 1'b0;
      end
    end else begin
      parse_body_byte(c);
      remaining = remaining - 1'b1;
      if (remaining == 0) begin
        emit_word(KIND_END, 8'h00, c == CHAR_NUL ? STATUS_OK : STATUS_NO_NUL, total_len);
        in_body = 1'b0;
        mode = MODE_NAME;
        held = 1'b0;
      end
    end
    if (expected_words.size() > base) expected_words[$].last = 1'b1;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && !byte_busy) begin
      if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        push <= 1'b1;
        byte_in_i <= pending_bytes.pop_front();
        byte_busy = 1'b1;
        push_gap = draw_gap(push_calm);
      end else begin
        push <= 1'b0;
      end
    end
    if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d data %02h", kind_o, data_byte_o));
        end else begin
          want = expected_words.pop_front();
          if (kind_o !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind_o, want.kind));
          if (data_byte_o !== want.data)
            report_mismatch($sformatf("data_byte %02h, want %02h", data_byte_o, want.data));
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
          if (block_len_o !== want.len)
            report_mismatch($sformatf("block_len %0d, want %0d", block_len_o, want.len));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", last_o, want.last));
        end
        pop_gap = draw_gap(pop_calm);
      end
      if (push && !full && byte_busy) begin
        predict_byte(byte_in_i);
        byte_busy = 1'b0;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    n_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] text_char();
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic queue_block(input int unsigned units, input tail_e tail);
    logic [7:0]  body[$];
    int unsigned n;
    n = units * LENGTH_UNIT;
    queue_byte(units[7:0]);
    while (body.size() < n) begin
      repeat ($urandom_range(1, 6)) body.push_back(text_char());
      body.push_back(CHAR_EQ);
      body.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 8)) body.push_back(text_char());
      body.push_back(CHAR_QUOTE);
      body.push_back(CHAR_SEMI);
    end
    while (body.size() > n) void'(body.pop_back());
    case (tail)
      TAIL_NUL: body[n-1] = CHAR_NUL;
      TAIL_EARLY_NUL: body[$urandom_range(0, n - 2)] = CHAR_NUL;
      TAIL_OPEN: body[n-1] = 8'($urandom_range(1, 255));
      TAIL_HELD: begin
        body[n-4] = CHAR_QUOTE;
        body[n-3] = CHAR_SEMI;
        body[n-2] = "k";
        body[n-1] = CHAR_EQ;
      end
      default: foreach (body[i]) body[i] = 8'($urandom_range(0, 255));
    endcase
    foreach (body[i]) queue_byte(body[i]);
  endtask

  task automatic queue_random_block();
    int unsigned r;
    int unsigned units_max;
    int unsigned units;
    tail_e       tail;
    r = $urandom_range(0, 99);
    units_max = max_len / LENGTH_UNIT;
    if (units_max > MAX_UNITS) units_max = MAX_UNITS;
    if (r < 8 || (r < 22 && units_max == MAX_UNITS)) begin
      queue_byte(8'($urandom_range(128, 255)));
    end else if (r < 14) begin
      queue_byte(8'h00);
    end else if (r < 22 || units_max == 0) begin
      queue_byte(8'($urandom_range(units_max + 1, MAX_UNITS)));
    end else begin
      units = $urandom_range(1, units_max < 2 ? units_max : 2);
      r = $urandom_range(0, 9);
      if (r < 4) tail = TAIL_NUL;
      else if (r < 6) tail = TAIL_EARLY_NUL;
      else if (r < 7) tail = TAIL_OPEN;
      else if (r < 9) tail = TAIL_HELD;
      else tail = TAIL_NOISE;
      queue_block(units, tail);
    end
  endtask

  task automatic queue_random_mix(input int unsigned count);
    int unsigned target;
    target = n_queued + count;
    while (n_queued < target) queue_random_block();
  endtask

  task automatic wait_idle(input int unsigned settle);
    while (pending_bytes.size() != 0 || byte_busy || expected_words.size() != 0)
      @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_max_block_len_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_len = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_max_len(12'd4080);

    queue_byte(8'h80);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_text("a==b='c'd';");
    queue_byte(CHAR_NUL);
    queue_text("x='Z");
    queue_block(1, TAIL_HELD);
    queue_random_mix(50);
    wait_idle(4);

    write_max_len(12'd0);
    queue_random_mix(15);
    wait_idle(4);

    write_max_len(12'd2032);
    queue_random_mix(20);
    wait_idle(4);

    write_max_len(12'd16);
    queue_random_mix(30);
    wait_idle(4);

    write_max_len(12'($urandom_range(0, 4080)));
    queue_random_mix(25);
    wait_idle(4);

    write_max_len(12'd2016);
    queue_byte(8'd127);
    queue_random_mix(15);
    wait_idle(8);

    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
